@@ sv/lts_pkg.sv @@
// Shared types, character codes and helper functions of the line tokenizer.
// Depends on nothing; used by the lexer step and the top level.
package lts_pkg;

   // Deepest bracket nesting that is counted; deeper openers saturate
   localparam int MAX_NEST = 255;
   localparam int NEST_W   = $clog2(MAX_NEST + 1);

   // Character codes
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_TAB     = 8'h09;
   localparam logic [7:0] CH_CR      = 8'h0D;
   localparam logic [7:0] CH_HASH    = 8'h23;
   localparam logic [7:0] CH_DQUOTE  = 8'h22;
   localparam logic [7:0] CH_SQUOTE  = 8'h27;
   localparam logic [7:0] CH_BSLASH  = 8'h5C;
   localparam logic [7:0] CH_LBRACE  = 8'h7B;
   localparam logic [7:0] CH_LSQUARE = 8'h5B;
   localparam logic [7:0] CH_LPAREN  = 8'h28;
   localparam logic [7:0] CH_RBRACE  = 8'h7D;
   localparam logic [7:0] CH_RSQUARE = 8'h5D;
   localparam logic [7:0] CH_RPAREN  = 8'h29;

   // Lexer modes; codes above COMMENT are never reached and act as idle
   typedef enum logic [2:0] {
      LEX_IDLE    = 3'd0,
      LEX_PLAIN   = 3'd1,
      LEX_QUOTED  = 3'd2,
      LEX_BRACKET = 3'd3,
      LEX_COMMENT = 3'd4
   } lex_mode_type;

   // Bracket kinds; the spare code behaves as a round bracket
   typedef enum logic [1:0] {
      BRK_BRACE  = 2'd0,
      BRK_SQUARE = 2'd1,
      BRK_PAREN  = 2'd2,
      BRK_SPARE  = 2'd3
   } bracket_kind_type;

   // Tokenizer state carried from item to item
   typedef struct packed {
      lex_mode_type      lex_mode;
      logic [7:0]        closing_quote;
      bracket_kind_type  bracket_kind;
      logic [NEST_W-1:0] nest_depth;
      logic              escape_pending;
      logic              inside_string;
   } lex_state_type;

   // One result item
   typedef struct packed {
      logic [7:0] out_char;
      logic       has_char;
      logic       token_end;
      logic       line_done;
   } lex_result_type;

   localparam lex_state_type LEX_STATE_RESET = '{
      lex_mode:       LEX_IDLE,
      closing_quote:  8'h00,
      bracket_kind:   BRK_BRACE,
      nest_depth:     '0,
      escape_pending: 1'b0,
      inside_string:  1'b0
   };

   // Space, TAB, LF, VT, FF and CR
   function automatic logic is_space(input logic [7:0] c);
      return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
   endfunction

   function automatic logic [7:0] open_of_kind(input bracket_kind_type k);
      logic [7:0] r;
      unique case (k)
         BRK_BRACE:  r = CH_LBRACE;
         BRK_SQUARE: r = CH_LSQUARE;
         default:    r = CH_LPAREN;
      endcase
      return r;
   endfunction

   function automatic logic [7:0] close_of_kind(input bracket_kind_type k);
      logic [7:0] r;
      unique case (k)
         BRK_BRACE:  r = CH_RBRACE;
         BRK_SQUARE: r = CH_RSQUARE;
         default:    r = CH_RPAREN;
      endcase
      return r;
   endfunction

endpackage

@@ sv/lts_if.sv @@
// Valid/ready channel interfaces for the tokenizer's input and result items.
// Depends on nothing.
interface lts_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] ch;
   logic       end_of_line;

   modport source (output valid, output ch, output end_of_line, input ready);
   modport sink   (input valid, input ch, input end_of_line, output ready);
endinterface

interface lts_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_char;
   logic       has_char;
   logic       token_end;
   logic       line_done;

   modport source (output valid, output out_char, output has_char,
                   output token_end, output line_done, input ready);
   modport sink   (input valid, input out_char, input has_char,
                   input token_end, input line_done, output ready);
endinterface

@@ sv/lts_lexer.sv @@
// One tokenizer step: next state and optional result for one input item.
// Depends on lts_pkg.
module lts_lexer (
   input  logic [7:0]             ch,
   input  logic                   end_of_line,
   input  lts_pkg::lex_state_type state_cur,
   output lts_pkg::lex_state_type state_nxt,
   output logic                   result_valid,
   output lts_pkg::lex_result_type result
);

   logic [7:0] open_ch;
   logic [7:0] close_ch;
   logic       space_ch;

   assign open_ch  = lts_pkg::open_of_kind(state_cur.bracket_kind);
   assign close_ch = lts_pkg::close_of_kind(state_cur.bracket_kind);
   assign space_ch = lts_pkg::is_space(ch);

   always_comb begin
      state_nxt    = state_cur;
      result_valid = 1'b0;
      result       = '{out_char: ch, has_char: 1'b1, token_end: 1'b0, line_done: 1'b0};

      if (end_of_line) begin
         // flush: report whether a token was open, then back to reset state
         state_nxt    = lts_pkg::LEX_STATE_RESET;
         result_valid = 1'b1;
         result.out_char  = 8'h00;
         result.has_char  = 1'b0;
         result.line_done = 1'b1;
         result.token_end = (state_cur.lex_mode == lts_pkg::LEX_PLAIN) ||
                            (state_cur.lex_mode == lts_pkg::LEX_QUOTED) ||
                            (state_cur.lex_mode == lts_pkg::LEX_BRACKET);
      end else begin
         unique case (state_cur.lex_mode)
            lts_pkg::LEX_PLAIN: begin
               result_valid = 1'b1;
               if (space_ch) begin
                  state_nxt.lex_mode = lts_pkg::LEX_IDLE;
                  result.out_char    = 8'h00;
                  result.has_char    = 1'b0;
                  result.token_end   = 1'b1;
               end
            end

            lts_pkg::LEX_QUOTED: begin
               result_valid = 1'b1;
               if (state_cur.escape_pending) begin
                  state_nxt.escape_pending = 1'b0;
               end else if (ch == lts_pkg::CH_BSLASH) begin
                  state_nxt.escape_pending = 1'b1;
               end else if (ch == state_cur.closing_quote) begin
                  state_nxt.lex_mode = lts_pkg::LEX_IDLE;
                  result.token_end   = 1'b1;
               end
            end

            lts_pkg::LEX_BRACKET: begin
               result_valid = 1'b1;
               if (state_cur.inside_string) begin
                  // string inside a bracketed token: brackets not counted
                  if (state_cur.escape_pending) begin
                     state_nxt.escape_pending = 1'b0;
                  end else if (ch == lts_pkg::CH_BSLASH) begin
                     state_nxt.escape_pending = 1'b1;
                  end else if (ch == lts_pkg::CH_DQUOTE) begin
                     state_nxt.inside_string = 1'b0;
                  end
               end else begin
                  if (ch == lts_pkg::CH_DQUOTE) begin
                     state_nxt.inside_string = 1'b1;
                  end else if (ch == open_ch) begin
                     // saturating depth count
                     if (state_cur.nest_depth < lts_pkg::NEST_W'(lts_pkg::MAX_NEST))
                        state_nxt.nest_depth = state_cur.nest_depth + lts_pkg::NEST_W'(1);
                  end else if (ch == close_ch) begin
                     if (state_cur.nest_depth <= lts_pkg::NEST_W'(1)) begin
                        state_nxt.nest_depth     = '0;
                        state_nxt.lex_mode       = lts_pkg::LEX_IDLE;
                        state_nxt.escape_pending = 1'b0;
                        state_nxt.inside_string  = 1'b0;
                        result.token_end         = 1'b1;
                     end else begin
                        state_nxt.nest_depth = state_cur.nest_depth - lts_pkg::NEST_W'(1);
                     end
                  end
               end
            end

            lts_pkg::LEX_COMMENT: begin
               // rest of the line is dropped
               result_valid = 1'b0;
            end

            default: begin
               // between tokens
               state_nxt.lex_mode = lts_pkg::LEX_IDLE;
               priority if (space_ch) begin
                  result_valid = 1'b0;
               end else if (ch == lts_pkg::CH_HASH) begin
                  state_nxt.lex_mode = lts_pkg::LEX_COMMENT;
               end else begin
                  result_valid             = 1'b1;
                  state_nxt.escape_pending = 1'b0;
                  state_nxt.inside_string  = 1'b0;
                  priority if ((ch == lts_pkg::CH_DQUOTE) || (ch == lts_pkg::CH_SQUOTE)) begin
                     state_nxt.lex_mode      = lts_pkg::LEX_QUOTED;
                     state_nxt.closing_quote = ch;
                  end else if ((ch == lts_pkg::CH_LBRACE) || (ch == lts_pkg::CH_LSQUARE) ||
                               (ch == lts_pkg::CH_LPAREN)) begin
                     state_nxt.lex_mode   = lts_pkg::LEX_BRACKET;
                     state_nxt.nest_depth = lts_pkg::NEST_W'(1);
                     priority if (ch == lts_pkg::CH_LBRACE)
                        state_nxt.bracket_kind = lts_pkg::BRK_BRACE;
                     else if (ch == lts_pkg::CH_LSQUARE)
                        state_nxt.bracket_kind = lts_pkg::BRK_SQUARE;
                     else
                        state_nxt.bracket_kind = lts_pkg::BRK_PAREN;
                  end else begin
                     state_nxt.lex_mode = lts_pkg::LEX_PLAIN;
                  end
               end
            end
         endcase
      end
   end

endmodule

@@ sv/line_tokenizer_stream_unit.sv @@
// Top level of the line tokenizer: state register, result register, handshakes.
// Depends on lts_pkg, lts_if (lts_req_if, lts_rsp_if) and lts_lexer.
//
//   channel   dir  payload                                   handshake
//   req_chan  in   ch[7:0], end_of_line                      valid/ready
//   rsp_chan  out  out_char[7:0], has_char, token_end,       valid/ready
//                  line_done
//
// One item per cycle: the lexer step is a single pass from the state register
// to the result register, so an item is taken every cycle the result register
// is empty or being emptied; its result is offered on the next cycle.
// Items that give no result are taken on the same terms and leave the output alone.
// Synchronous active-high reset returns the lexer to idle and empties the output.
// A stalled result holds; input is refused only while it waits.
module line_tokenizer_stream_unit (
   input  logic             clock,
   input  logic             reset,
   lts_req_if.sink          req_chan,
   lts_rsp_if.source        rsp_chan
);

   lts_pkg::lex_state_type  state_ff;
   lts_pkg::lex_state_type  state_in;
   lts_pkg::lex_result_type result_ff;
   lts_pkg::lex_result_type result_in;
   logic                    result_valid;
   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;
   logic                    req_take;

   // combinational step for the item at the port
   lts_lexer u_lexer (
      .ch           (req_chan.ch),
      .end_of_line  (req_chan.end_of_line),
      .state_cur    (state_ff),
      .state_nxt    (state_in),
      .result_valid (result_valid),
      .result       (result_in)
   );

   // accept whenever the result register is free or drains this cycle
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign req_take       = req_chan.valid && req_chan.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_chan.ready)
         rsp_valid_in = 1'b0;
      if (req_take && result_valid)
         rsp_valid_in = 1'b1;
   end

   // lexer state
   always_ff @(posedge clock) begin
      if (reset)
         state_ff <= lts_pkg::LEX_STATE_RESET;
      else if (req_take)
         state_ff <= state_in;
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset)
         rsp_valid_ff <= 1'b0;
      else
         rsp_valid_ff <= rsp_valid_in;
   end

   always_ff @(posedge clock) begin
      if (req_take && result_valid)
         result_ff <= result_in;
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.out_char  = result_ff.out_char;
   assign rsp_chan.has_char  = result_ff.has_char;
   assign rsp_chan.token_end = result_ff.token_end;
   assign rsp_chan.line_done = result_ff.line_done;

`ifndef NO_ASSERTIONS
   // an accepted end of line leaves the lexer idle with no depth
   a_eol_resets: assert property (@(posedge clock) disable iff (reset)
      (req_take && req_chan.end_of_line) |=>
         (state_ff.lex_mode == lts_pkg::LEX_IDLE) && (state_ff.nest_depth == '0))
      else $error("end of line did not return lexer to idle");

   // a bracketed token always has a nonzero depth
   a_bracket_depth: assert property (@(posedge clock) disable iff (reset)
      (state_ff.lex_mode == lts_pkg::LEX_BRACKET) |-> (state_ff.nest_depth != '0))
      else $error("bracketed token with zero depth");

   // a result without a character is either a separator or a line end
   a_empty_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !result_ff.has_char) |->
         (result_ff.token_end || result_ff.line_done))
      else $error("empty result that ends nothing");

   // line end results carry no character
   a_line_done_char: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && result_ff.line_done) |->
         (!result_ff.has_char && (result_ff.out_char == 8'h00)))
      else $error("line end result carries a character");
`endif

endmodule
